@@ src/dos_pkg.sv @@
// ----------------------------------------------------------------------------
// dos_pkg
// Shared sizes, codes and types of the dependency order unit.
// ----------------------------------------------------------------------------
package dos_pkg;

   localparam int MAX_OBJECTS = 32;
   localparam int MAX_EDGES   = 128;
   localparam int TAG_BITS    = 16;

   localparam int SLOT_W = $clog2(MAX_OBJECTS);
   localparam int OCNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int EIDX_W = $clog2(MAX_EDGES);
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);
   localparam int RES_W  = OCNT_W;

   localparam logic [RES_W-1:0] NO_SLOT = RES_W'(MAX_OBJECTS);

   typedef enum logic [1:0] {
      ACT_ADD_OBJ = 2'd0,
      ACT_ADD_DEP = 2'd1,
      ACT_ARRANGE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   dep;
      logic [TAG_BITS-1:0] target;
      logic [RES_W-1:0]    resolved;
   } edge_type;

   localparam int EDGE_W = $bits(edge_type);

endpackage

@@ src/dos_ram.sv @@
// ----------------------------------------------------------------------------
// dos_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module dos_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/dependency_order_with_cycle_split_unit.sv @@
// ----------------------------------------------------------------------------
// dependency_order_with_cycle_split_unit
// Loads object tags and dependency edges, then emits the objects in
// dependency order and the leftover ones marked cycled.
// ----------------------------------------------------------------------------
// Usage: each request word on req_* carries an action in req_tuser and the
// tags in req_tdata. Add object, add dependency and clear store give one
// response word each; arrange gives one word per loaded object (or one
// status word when the store is empty), rsp_tlast marks the final one.
// Tags sit in a 32-entry ram, edges in a 128-entry ram, both read through
// a registered port; placed flags are flip-flops. An edge stays live until
// the object it resolved to has been placed.
// Add object and clear answer from the emit state after acceptance. Add
// dependency scans the tag ram, object by object, up to the match, then
// answers. Arrange first resolves each edge by scanning the tag ram, then
// for each regular word picks an object, emits it and, when edges are
// loaded, makes a pass over the edge ram; it ends with a pass over the
// objects that emits one cycled word per unplaced object.
// One request is worked at a time; req_tready is high when the sequencer
// is idle. A response waits in the output register while rsp_tready is low
// and the sequencer stalls until it is taken.
// Reset empties the store and drops any pending response.
// ----------------------------------------------------------------------------
module dependency_order_with_cycle_split_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // object_tag[15:0], depends_on_tag[31:16]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_tag[15:0], cycled[16], status[18:17]
   output logic        rsp_tlast
);
   import dos_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_USE, S_RES_ERD, S_RES_EUSE, S_RES_SRD,
      S_RES_SUSE, S_PICK, S_RET_RD, S_RET_USE, S_CYC_CHK, S_EMIT
   } state_type;

   state_type           state_ff, ret_ff;
   logic [OCNT_W-1:0]   obj_cnt_ff, i_ff, k_ff;
   logic [ECNT_W-1:0]   edge_cnt_ff, e_ff;
   logic [MAX_OBJECTS-1:0] placed_ff, mask_ff;
   logic [TAG_BITS-1:0] tag_ff, dep_ff;
   edge_type            cur_edge_ff;
   logic                emit_mem_ff, emit_cyc_ff, emit_last_ff;
   status_type          emit_st_ff;
   logic                rsp_valid_ff, rsp_last_ff, rsp_cyc_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;
   status_type          rsp_st_ff;

   // ram ports
   logic                slot_we, slot_re;
   logic [SLOT_W-1:0]   slot_waddr, slot_raddr;
   logic [TAG_BITS-1:0] slot_wdata, slot_rdata;
   logic                edge_we, edge_re;
   logic [EIDX_W-1:0]   edge_waddr, edge_raddr;
   edge_type            edge_wdata, edge_rd;
   logic [EDGE_W-1:0]   edge_rdata;

   logic                accept;
   action_type          act;
   logic [TAG_BITS-1:0] in_tag, in_dep;
   logic                slot_match, res_match, found;
   logic [SLOT_W-1:0]   pick_slot;
   logic                k_last, out_free, ret_live;

   assign accept   = req_tvalid && req_tready;
   assign act      = action_type'(req_tuser);
   assign in_tag   = req_tdata[15:0];
   assign in_dep   = req_tdata[31:16];
   assign edge_rd  = edge_type'(edge_rdata);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign k_last   = (OCNT_W'(k_ff + 1'b1) == obj_cnt_ff);

   assign slot_match = (slot_rdata == tag_ff);
   assign res_match  = (slot_rdata == cur_edge_ff.target);
   // live while the resolved object is still unplaced; unresolved stays live
   assign ret_live   = !((edge_rd.resolved != NO_SLOT) &&
                         placed_ff[edge_rd.resolved[SLOT_W-1:0]]);

   // earliest unplaced object with no live edges
   always_comb begin
      found     = 1'b0;
      pick_slot = '0;
      for (int j = MAX_OBJECTS - 1; j >= 0; j--) begin
         if (!placed_ff[j] && !mask_ff[j] && (OCNT_W'(j) < obj_cnt_ff)) begin
            found     = 1'b1;
            pick_slot = SLOT_W'(j);
         end
      end
   end

   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = obj_cnt_ff[SLOT_W-1:0];
      slot_wdata = in_tag;
      slot_re    = 1'b0;
      slot_raddr = i_ff[SLOT_W-1:0];
      edge_we    = 1'b0;
      edge_waddr = edge_cnt_ff[EIDX_W-1:0];
      edge_wdata = '{dep: i_ff[SLOT_W-1:0], target: dep_ff, resolved: NO_SLOT};
      edge_re    = 1'b0;
      edge_raddr = e_ff[EIDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            slot_we = accept && (act == ACT_ADD_OBJ) &&
                      (obj_cnt_ff < OCNT_W'(MAX_OBJECTS));
         end
         S_FIND_RD, S_RES_SRD: slot_re = 1'b1;
         S_FIND_USE: begin
            edge_we = slot_match && (edge_cnt_ff < ECNT_W'(MAX_EDGES));
         end
         S_RES_ERD, S_RET_RD: edge_re = 1'b1;
         S_RES_SUSE: begin
            edge_waddr = e_ff[EIDX_W-1:0];
            edge_wdata = '{dep: cur_edge_ff.dep, target: cur_edge_ff.target,
                           resolved: res_match ? i_ff : NO_SLOT};
            edge_we    = res_match || (OCNT_W'(i_ff + 1'b1) == obj_cnt_ff);
         end
         S_PICK: begin
            slot_re    = found;
            slot_raddr = pick_slot;
         end
         S_CYC_CHK: begin
            slot_re = (i_ff != obj_cnt_ff) && !placed_ff[i_ff[SLOT_W-1:0]];
         end
         default: ;
      endcase
   end

   dos_ram #(.WIDTH(TAG_BITS), .DEPTH(MAX_OBJECTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   dos_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .re    (edge_re),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         obj_cnt_ff   <= '0;
         edge_cnt_ff  <= '0;
         placed_ff    <= '0;
         mask_ff      <= '0;
         i_ff         <= '0;
         e_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               emit_mem_ff  <= 1'b0;
               emit_cyc_ff  <= 1'b0;
               emit_last_ff <= 1'b1;
               ret_ff       <= S_IDLE;
               tag_ff       <= in_tag;
               dep_ff       <= in_dep;
               i_ff         <= '0;
               if (accept) begin
                  unique case (act)
                     ACT_ADD_OBJ: begin
                        if (obj_cnt_ff < OCNT_W'(MAX_OBJECTS)) begin
                           obj_cnt_ff <= OCNT_W'(obj_cnt_ff + 1'b1);
                           emit_st_ff <= ST_OK;
                        end else begin
                           emit_st_ff <= ST_FULL;
                        end
                        state_ff <= S_EMIT;
                     end
                     ACT_ADD_DEP: begin
                        if (obj_cnt_ff == '0) begin
                           emit_st_ff <= ST_UNKNOWN;
                           state_ff   <= S_EMIT;
                        end else begin
                           emit_st_ff <= ST_OK;
                           state_ff   <= S_FIND_RD;
                        end
                     end
                     ACT_ARRANGE: begin
                        placed_ff <= '0;
                        mask_ff   <= '0;
                        k_ff      <= '0;
                        e_ff      <= '0;
                        if (obj_cnt_ff == '0) begin
                           edge_cnt_ff <= '0;
                           emit_st_ff  <= ST_EMPTY;
                           state_ff    <= S_EMIT;
                        end else if (edge_cnt_ff == '0) begin
                           state_ff <= S_PICK;
                        end else begin
                           state_ff <= S_RES_ERD;
                        end
                     end
                     ACT_CLEAR: begin
                        obj_cnt_ff  <= '0;
                        edge_cnt_ff <= '0;
                        placed_ff   <= '0;
                        emit_st_ff  <= ST_OK;
                        state_ff    <= S_EMIT;
                     end
                     default: ;
                  endcase
               end
            end
            S_FIND_RD: state_ff <= S_FIND_USE;
            S_FIND_USE: begin
               if (slot_match) begin
                  if (edge_cnt_ff < ECNT_W'(MAX_EDGES)) begin
                     edge_cnt_ff <= ECNT_W'(edge_cnt_ff + 1'b1);
                  end else begin
                     emit_st_ff <= ST_FULL;
                  end
                  state_ff <= S_EMIT;
               end else if (OCNT_W'(i_ff + 1'b1) == obj_cnt_ff) begin
                  emit_st_ff <= ST_UNKNOWN;
                  state_ff   <= S_EMIT;
               end else begin
                  i_ff     <= OCNT_W'(i_ff + 1'b1);
                  state_ff <= S_FIND_RD;
               end
            end
            S_RES_ERD: state_ff <= S_RES_EUSE;
            S_RES_EUSE: begin
               cur_edge_ff <= edge_rd;
               i_ff        <= '0;
               state_ff    <= S_RES_SRD;
            end
            S_RES_SRD: state_ff <= S_RES_SUSE;
            S_RES_SUSE: begin
               if (res_match || (OCNT_W'(i_ff + 1'b1) == obj_cnt_ff)) begin
                  mask_ff[cur_edge_ff.dep]  <= 1'b1;
                  e_ff <= ECNT_W'(e_ff + 1'b1);
                  state_ff <= (ECNT_W'(e_ff + 1'b1) == edge_cnt_ff) ? S_PICK
                                                                    : S_RES_ERD;
               end else begin
                  i_ff     <= OCNT_W'(i_ff + 1'b1);
                  state_ff <= S_RES_SRD;
               end
            end
            S_PICK: begin
               if (found) begin
                  placed_ff[pick_slot] <= 1'b1;
                  emit_mem_ff  <= 1'b1;
                  emit_cyc_ff  <= 1'b0;
                  emit_st_ff   <= ST_OK;
                  emit_last_ff <= k_last;
                  mask_ff      <= '0;
                  e_ff         <= '0;
                  ret_ff       <= (edge_cnt_ff == '0) ? S_PICK : S_RET_RD;
                  state_ff     <= S_EMIT;
               end else begin
                  i_ff     <= '0;
                  state_ff <= S_CYC_CHK;
               end
            end
            S_RET_RD: state_ff <= S_RET_USE;
            S_RET_USE: begin
               // rebuild the live-reference mask after the pick
               if (ret_live) begin
                  mask_ff[edge_rd.dep] <= 1'b1;
               end
               e_ff <= ECNT_W'(e_ff + 1'b1);
               state_ff <= (ECNT_W'(e_ff + 1'b1) == edge_cnt_ff) ? S_PICK : S_RET_RD;
            end
            S_CYC_CHK: begin
               if (i_ff == obj_cnt_ff) begin
                  obj_cnt_ff  <= '0;
                  edge_cnt_ff <= '0;
                  placed_ff   <= '0;
                  state_ff    <= S_IDLE;
               end else begin
                  i_ff <= OCNT_W'(i_ff + 1'b1);
                  if (!placed_ff[i_ff[SLOT_W-1:0]]) begin
                     emit_mem_ff  <= 1'b1;
                     emit_cyc_ff  <= 1'b1;
                     emit_st_ff   <= ST_OK;
                     emit_last_ff <= k_last;
                     ret_ff       <= S_CYC_CHK;
                     state_ff     <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_tag_ff   <= emit_mem_ff ? slot_rdata : '0;
                  rsp_cyc_ff   <= emit_cyc_ff;
                  rsp_st_ff    <= emit_st_ff;
                  rsp_last_ff  <= emit_last_ff;
                  k_ff         <= OCNT_W'(k_ff + 1'b1);
                  state_ff     <= ret_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_st_ff, rsp_cyc_ff, rsp_tag_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/dependency_order_with_cycle_split_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dependency_order_with_cycle_split_unit_tb
// Drives load, edge, arrange and clear requests into the ordering unit and
// checks every response word against a predictor of the dependency order.
// ----------------------------------------------------------------------------
module dependency_order_with_cycle_split_unit_tb;
   import dos_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 340;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      action_type        act;
      logic [15:0]       obj_tag;
      logic [15:0]       dep_tag;
   } request_item;

   typedef struct {
      logic [15:0] out_tag;
      logic        cycled;
      status_type  status;
      logic        last;
   } order_word;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // object_tag[15:0], depends_on_tag[31:16]
   logic [1:0]  req_tuser = '0;  // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // out_tag[15:0], cycled[16], status[18:17]
   logic        rsp_tlast;

   request_item pending_items[$];
   order_word   expected_words[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          hold_left   = 0;
   logic        req_taken   = 1'b0;

   // predictor copy of the store
   logic [15:0]       obj_tags [MAX_OBJECTS];
   int                obj_count = 0;
   int                edge_dep_slot [MAX_EDGES];
   logic [15:0]       edge_target [MAX_EDGES];
   int                edge_total = 0;

   dependency_order_with_cycle_split_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int find_object(logic [15:0] tag);
      for (int i = 0; i < obj_count; i++)
         if (obj_tags[i] == tag) return i;
      return MAX_OBJECTS;
   endfunction

   function automatic void push_word(logic [15:0] tag, logic cyc, status_type st,
                                     logic last);
      order_word w;
      w.out_tag = tag;
      w.cycled  = cyc;
      w.status  = st;
      w.last    = last;
      expected_words.push_back(w);
   endfunction

   function automatic void predict_order(action_type act, logic [15:0] tag,
                                         logic [15:0] dep);
      int  slot;
      int  pick;
      int  resolved [MAX_EDGES];
      bit  live [MAX_EDGES];
      bit  placed [MAX_OBJECTS];
      bit  blocked;
      case (act)
         ACT_ADD_OBJ: begin
            if (obj_count >= MAX_OBJECTS) begin
               push_word('0, 1'b0, ST_FULL, 1'b1);
            end else begin
               obj_tags[obj_count] = tag;
               obj_count++;
               push_word('0, 1'b0, ST_OK, 1'b1);
            end
         end
         ACT_ADD_DEP: begin
            slot = find_object(tag);
            if (slot == MAX_OBJECTS) begin
               push_word('0, 1'b0, ST_UNKNOWN, 1'b1);
            end else if (edge_total >= MAX_EDGES) begin
               push_word('0, 1'b0, ST_FULL, 1'b1);
            end else begin
               edge_dep_slot[edge_total] = slot;
               edge_target[edge_total]   = dep;
               edge_total++;
               push_word('0, 1'b0, ST_OK, 1'b1);
            end
         end
         ACT_ARRANGE: begin
            if (obj_count == 0) begin
               push_word('0, 1'b0, ST_EMPTY, 1'b1);
            end else begin
               for (int e = 0; e < edge_total; e++) begin
                  resolved[e] = find_object(edge_target[e]);
                  live[e]     = 1'b1;
               end
               for (int i = 0; i < obj_count; i++) placed[i] = 1'b0;
               forever begin
                  pick = MAX_OBJECTS;
                  for (int i = 0; i < obj_count && pick == MAX_OBJECTS; i++) begin
                     blocked = placed[i];
                     for (int e = 0; e < edge_total; e++)
                        if (live[e] && edge_dep_slot[e] == i) blocked = 1'b1;
                     if (!blocked) pick = i;
                  end
                  if (pick == MAX_OBJECTS) break;
                  placed[pick] = 1'b1;
                  push_word(obj_tags[pick], 1'b0, ST_OK, 1'b0);
                  for (int e = 0; e < edge_total; e++)
                     if (resolved[e] == pick) live[e] = 1'b0;
               end
               // leftovers sit in or behind a cycle, or behind an unresolved target
               for (int i = 0; i < obj_count; i++)
                  if (!placed[i]) push_word(obj_tags[i], 1'b1, ST_OK, 1'b0);
               expected_words[expected_words.size() - 1].last = 1'b1;
            end
            obj_count  = 0;
            edge_total = 0;
         end
         default: begin
            obj_count  = 0;
            edge_total = 0;
            push_word('0, 1'b0, ST_OK, 1'b1);
         end
      endcase
   endfunction

   task automatic queue_request(action_type act, logic [15:0] tag, logic [15:0] dep);
      request_item it;
      it.act     = act;
      it.obj_tag = tag;
      it.dep_tag = dep;
      pending_items.push_back(it);
   endtask

   function automatic logic [15:0] pool_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 7));
      if (r < 80) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // stall windows: no random stalls during the quiet stretch
   function automatic bit quiet_stretch();
      return cycle_count >= 8000 && cycle_count < 16000;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) req_taken <= !reset && req_tvalid && req_tready;

   always @(negedge clock) begin
      request_item it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_items.size() != 0 &&
             (quiet_stretch() || $urandom_range(0, 99) >= 14)) begin
            it = pending_items.pop_front();
            req_tdata  <= {it.dep_tag, it.obj_tag};
            req_tuser  <= it.act;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold so the unit backs up its input
   always @(negedge clock) begin
      if (cycle_count == 4000) begin
         hold_left  <= 500;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && (quiet_stretch() || $urandom_range(0, 99) >= 14);
      end
   end

   // predictor on accepted requests, checker on accepted responses
   always @(posedge clock) begin
      order_word w;
      if (!reset && req_tvalid && req_tready)
         predict_order(action_type'(req_tuser), req_tdata[15:0], req_tdata[31:16]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            error_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_tdata[15:0] !== w.out_tag) begin
               $error("out_tag expected %h actual %h", w.out_tag, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[16] !== w.cycled) begin
               $error("cycled expected %b actual %b", w.cycled, rsp_tdata[16]);
               error_count++;
            end
            if (rsp_tdata[18:17] !== w.status) begin
               $error("status expected %0d actual %0d", w.status, rsp_tdata[18:17]);
               error_count++;
            end
            if (rsp_tlast !== w.last) begin
               $error("last expected %b actual %b", w.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      int          n_obj;
      int          n_dep;
      int          sent;
      logic [15:0] loaded [$];
      logic [15:0] t;
      logic [15:0] d;

      // directed: empty arrange, unknown dependent, duplicates, self and
      // unresolved edges, clear with edges present
      queue_request(ACT_ARRANGE, 16'h0000, 16'h0000);
      queue_request(ACT_ADD_DEP, 16'hAAAA, 16'h5555);
      queue_request(ACT_ADD_OBJ, 16'h0000, 16'hFFFF);
      queue_request(ACT_ADD_OBJ, 16'hFFFF, 16'h0000);
      queue_request(ACT_ADD_OBJ, 16'hFFFF, 16'h1234);
      queue_request(ACT_ADD_OBJ, 16'h0007, 16'h0000);
      queue_request(ACT_ADD_OBJ, 16'h0009, 16'h0000);
      queue_request(ACT_ADD_DEP, 16'hFFFF, 16'h0000);
      queue_request(ACT_ADD_DEP, 16'h0000, 16'h1234);
      queue_request(ACT_ADD_DEP, 16'h0007, 16'h0007);
      queue_request(ACT_ADD_DEP, 16'h0009, 16'hFFFF);
      queue_request(ACT_ADD_DEP, 16'h0001, 16'h0009);
      queue_request(ACT_ARRANGE, 16'hFFFF, 16'hFFFF);
      queue_request(ACT_ADD_OBJ, 16'h0001, 16'h0000);
      queue_request(ACT_ADD_OBJ, 16'h0002, 16'h0000);
      queue_request(ACT_ADD_DEP, 16'h0001, 16'h0002);
      queue_request(ACT_ADD_DEP, 16'h0002, 16'h0001);
      queue_request(ACT_ARRANGE, 16'h0000, 16'h0000);
      queue_request(ACT_ADD_OBJ, 16'h0003, 16'h0000);
      queue_request(ACT_ADD_DEP, 16'h0003, 16'h0004);
      queue_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
      queue_request(ACT_ARRANGE, 16'h0000, 16'h0000);

      // fill the edge list past its end
      queue_request(ACT_ADD_OBJ, 16'h0011, 16'h0000);
      queue_request(ACT_ADD_OBJ, 16'h0012, 16'h0000);
      for (int e = 0; e < MAX_EDGES + 2; e++)
         queue_request(ACT_ADD_DEP, 16'h0011, 16'($urandom_range(16'h10, 16'h13)));
      queue_request(ACT_ARRANGE, 16'h0000, 16'h0000);
      sent = MAX_EDGES + 5;

      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 99) < 30) begin
               queue_request(ACT_CLEAR, 16'($urandom), 16'($urandom));
               sent++;
            end
            n_obj = ($urandom_range(0, 99) < 4) ? $urandom_range(MAX_OBJECTS, MAX_OBJECTS + 2)
                                                 : $urandom_range(1, 8);
            loaded.delete();
            for (int i = 0; i < n_obj; i++) begin
               t = pool_tag();
               loaded.push_back(t);
               queue_request(ACT_ADD_OBJ, t, 16'($urandom));
            end
            n_dep = $urandom_range(0, 2 * (n_obj > 8 ? 8 : n_obj));
            for (int i = 0; i < n_dep; i++) begin
               t = ($urandom_range(0, 99) < 90) ? loaded[$urandom_range(0, n_obj - 1)]
                                                 : 16'($urandom);
               d = ($urandom_range(0, 99) < 85) ? loaded[$urandom_range(0, n_obj - 1)]
                                                 : 16'($urandom);
               queue_request(ACT_ADD_DEP, t, d);
            end
            queue_request(ACT_ARRANGE, 16'($urandom), 16'($urandom));
            sent += n_obj + n_dep + 1;
         end else begin
            queue_request(action_type'($urandom_range(0, 3)), pool_tag(), 16'($urandom));
            sent++;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
